// ----- rtl/assert_macros.svh -----
// Assertion macros for the double-ended priority queue RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/depq_pkg.sv -----
// Shared types and constants for the double-ended priority queue.
// Depends on nothing; imported by the cell and the top level.
`timescale 1ns / 1ps

package depq_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_POP_MAX = 2'd1,
    REQ_POP_MIN = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast from the top level to every cell in the row.
  typedef struct packed {
    logic                     ins;    // insert word at its sorted place
    logic                     shift;  // pop smallest: move every word down
    logic signed [DATA_W-1:0] value;
    logic        [CNT_W-1:0]  count;
  } ctl_t;

endpackage

// ----- rtl/depq_cell.sv -----
// One place of the sorted row: holds a word, compares it with the broadcast value.
// Depends on depq_pkg.
`timescale 1ns / 1ps

module depq_cell
  import depq_pkg::*;
(
  input  logic                     clk,
  input  logic        [IDX_W-1:0]  idx,
  input  ctl_t                     ctl,
  input  logic signed [DATA_W-1:0] prev_val,
  input  logic                     prev_gt,
  input  logic signed [DATA_W-1:0] next_val,
  output logic signed [DATA_W-1:0] val,
  output logic                     gt,
  output logic signed [DATA_W-1:0] tap
);

  logic occ;
  logic at_end;
  logic last;

  // Decode position against the fill count
  always_comb begin
    occ    = {{(CNT_W-IDX_W){1'b0}}, idx} < ctl.count;
    at_end = {{(CNT_W-IDX_W){1'b0}}, idx} == ctl.count;
    last   = ({{(CNT_W-IDX_W){1'b0}}, idx} + CNT_W'(1)) == ctl.count;
    gt     = occ && (val > ctl.value);
    tap    = last ? val : '0;
  end

  // Shift up on insert, shift down on pop smallest, else hold
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (prev_gt) begin
        val <= prev_val;
      end else if (gt || at_end) begin
        val <= ctl.value;
      end
    end else if (ctl.shift && occ) begin
      val <= next_val;
    end
  end

endmodule

// ----- rtl/double_ended_priority_queue.sv -----
// Top level of the double-ended priority queue: fill count, cell row, result register.
// Depends on depq_pkg, depq_cell and assert_macros.svh.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------
//  request   | start / busy       | req_type, value
//  result    | done (one cycle)   | popped_value, status
//
// The whole cell row compares and shifts in the cycle a request is accepted,
// and the result appears on the following cycle.
// A request may be issued every cycle; busy is high only during reset and in the cycle after it.
// Reset clears the fill count; the stored words need no clearing.
// The result is shown for one cycle and cannot be stalled by the receiver.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module double_ended_priority_queue
  import depq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic        [1:0]        req_type,
  input  logic signed [DATA_W-1:0] value,
  output logic                     done,
  output logic signed [DATA_W-1:0] popped_value,
  output logic        [1:0]        status
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             is_full;
  logic             is_empty;
  ctl_t             ctl;

  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic                     cell_gt  [CAPACITY];
  logic signed [DATA_W-1:0] cell_tap [CAPACITY];
  logic signed [DATA_W-1:0] max_word;
  logic signed [DATA_W-1:0] res_val_next;
  logic        [1:0]        res_st_next;

  assign accept   = start && !busy;
  assign is_full  = count == CNT_W'(CAPACITY);
  assign is_empty = count == '0;

  // Build the broadcast word for the row
  always_comb begin
    ctl.value = value;
    ctl.count = count;
    ctl.ins   = accept && (req_type == REQ_INSERT) && !is_full;
    ctl.shift = accept && (req_type == REQ_POP_MIN) && !is_empty;
  end

  // Row of cells, each linked to its neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] pv;
    logic                     pg;
    logic signed [DATA_W-1:0] nv;
    if (i == 0) begin : g_first
      assign pv = '0;
      assign pg = 1'b0;
    end else begin : g_mid
      assign pv = cell_val[i-1];
      assign pg = cell_gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign nv = cell_val[i];
    end else begin : g_inner
      assign nv = cell_val[i+1];
    end
    depq_cell u_cell (
      .clk      (clk),
      .idx      (IDX_W'(i)),
      .ctl      (ctl),
      .prev_val (pv),
      .prev_gt  (pg),
      .next_val (nv),
      .val      (cell_val[i]),
      .gt       (cell_gt[i]),
      .tap      (cell_tap[i])
    );
  end

  // Merge the one-hot taps: only the top occupied cell drives a word
  always_comb begin
    max_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      max_word = max_word | cell_tap[i];
    end
  end

  // Work out the count and the result word
  always_comb begin
    count_next   = count;
    res_val_next = '0;
    res_st_next  = ST_OK;
    if (accept) begin
      case (req_type)
        REQ_INSERT: begin
          if (is_full) begin
            res_st_next = ST_FULL;
          end else begin
            count_next = count + CNT_W'(1);
          end
        end
        REQ_POP_MAX: begin
          if (is_empty) begin
            res_st_next = ST_EMPTY;
          end else begin
            count_next   = count - CNT_W'(1);
            res_val_next = max_word;
          end
        end
        REQ_POP_MIN: begin
          if (is_empty) begin
            res_st_next = ST_EMPTY;
          end else begin
            count_next   = count - CNT_W'(1);
            res_val_next = cell_val[0];
          end
        end
        default: begin
          res_st_next = ST_OK;
        end
      endcase
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      busy  <= 1'b0;
      done  <= accept;
    end
  end

  // Register the result word
  always_ff @(posedge clk) begin
    popped_value <= res_val_next;
    status       <= res_st_next;
  end

  `ASSERT_NEXT(a_result_follows, clk, rst, accept, done)
  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(CAPACITY))
  `ASSERT_IMPL(a_error_zero, clk, rst, done && (status != ST_OK), popped_value == '0)
  `ASSERT_NEXT(a_full_holds, clk, rst, accept && (req_type == REQ_INSERT) && is_full, $stable(count))

endmodule
